/* design/sbb_pkg.sv */
// ----------------------------------------------------------------------------
// sbb_pkg: shared types, constants and arithmetic for the blur and blend block
// Holds the line geometry, the per-beat control word, the result word and the
// fixed-point forms of the 3-tap blur and of the blend.
// ----------------------------------------------------------------------------
package sbb_pkg;

    // Line geometry
    localparam int unsigned MAX_WIDTH = 2048;
    localparam int unsigned COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned CNT_W     = COL_W + 1;

    // Field widths
    localparam int unsigned CH_W      = 8;
    localparam int unsigned NUM_LANES = 3;
    localparam int unsigned PIX_W     = CH_W * NUM_LANES;
    localparam int unsigned CFG_WID_W = 12;
    localparam int unsigned CFG_HGT_W = 16;
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned DATA_W    = 32;

    // Register reset values
    localparam logic [CFG_WID_W-1:0] RESET_WIDTH  = 12'd2048;
    localparam logic [CFG_HGT_W-1:0] RESET_HEIGHT = 16'd1;

    // Reciprocals: floor(x/259) for x < 2^17, floor(x/255) for x < 2^16
    localparam logic [17:0] BLUR_RECIP  = 18'd259108;
    localparam int unsigned BLUR_SHIFT  = 26;
    localparam logic [16:0] BLEND_RECIP = 17'd65794;
    localparam int unsigned BLEND_SHIFT = 24;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    // Control that travels with a beat down the pipeline
    typedef struct packed {
        logic valid;
        logic first_row;
        logic flush;
        logic col_zero;
        logic last_col;
    } t_ctl;

    // One result beat
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             last_of_run;
        logic             last_of_frame;
    } t_result;

    // (129 + 255*c + 2*(a+b)) / 259
    function automatic logic [CH_W-1:0] blur3(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] c,
                                              input logic [CH_W-1:0] b);
        logic [16:0] sum;
        logic [34:0] prod;
        sum  = 17'd129 + (17'(c) << 8) - 17'(c) + (17'(a) << 1) + (17'(b) << 1);
        prod = 35'(sum) * 35'(BLUR_RECIP);
        return prod[BLUR_SHIFT +: CH_W];
    endfunction

    // (2*blur + 253*orig) / 255
    function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] orig,
                                              input logic [CH_W-1:0] bl);
        logic [15:0] sum;
        logic [32:0] prod;
        sum  = (16'(bl) << 1) + 16'(orig) * 16'd253;
        prod = 33'(sum) * 33'(BLEND_RECIP);
        return prod[BLEND_SHIFT +: CH_W];
    endfunction

endpackage

/* design/sbb_line_store.sv */
// ----------------------------------------------------------------------------
// sbb_line_store: the two line memories (row above, middle row)
// One registered read and one write per cycle for each memory; a write to the
// address read in the same cycle is forwarded to the read data.
// ----------------------------------------------------------------------------
module sbb_line_store
    import sbb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_addr,
    input  logic             i_wr_en,
    input  logic [COL_W-1:0] i_wr_addr,
    input  logic [PIX_W-1:0] i_wr_above,
    input  logic [PIX_W-1:0] i_wr_middle,
    output logic [PIX_W-1:0] o_above,
    output logic [PIX_W-1:0] o_middle
);

    logic [PIX_W-1:0] r_mem_above  [MAX_WIDTH];
    logic [PIX_W-1:0] r_mem_middle [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_above;
    logic [PIX_W-1:0] r_rd_middle;
    logic [PIX_W-1:0] r_fwd_above;
    logic [PIX_W-1:0] r_fwd_middle;
    logic             r_fwd;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_above[i_wr_addr]  <= i_wr_above;
            r_mem_middle[i_wr_addr] <= i_wr_middle;
        end
    end

    // Read port, capture a same-cycle write for forwarding
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_above   <= r_mem_above[i_rd_addr];
            r_rd_middle  <= r_mem_middle[i_rd_addr];
            r_fwd        <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_above  <= i_wr_above;
            r_fwd_middle <= i_wr_middle;
        end
    end

    assign o_above  = r_fwd ? r_fwd_above  : r_rd_above;
    assign o_middle = r_fwd ? r_fwd_middle : r_rd_middle;

endmodule

/* design/sbb_lane.sv */
// ----------------------------------------------------------------------------
// sbb_lane: blur and blend datapath for one byte channel
// Vertical tap on the line store data, horizontal tap over a three-wide window
// of vertical results, then both possible blends of the beat.
// ----------------------------------------------------------------------------
module sbb_lane
    import sbb_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_s1_flush,
    input  t_ctl            i_s2,
    input  logic [CH_W-1:0] i_above,
    input  logic [CH_W-1:0] i_center,
    input  logic [CH_W-1:0] i_px,
    output logic [CH_W-1:0] o_res1,
    output logic [CH_W-1:0] o_res2
);

    logic [CH_W-1:0] s1_below;
    logic [CH_W-1:0] s1_v;
    logic [CH_W-1:0] r_v;
    logic [CH_W-1:0] r_pix_c;
    logic [CH_W-1:0] r_left;
    logic [CH_W-1:0] r_center;
    logic [CH_W-1:0] r_orig;
    logic [CH_W-1:0] s2_new_left;
    logic [CH_W-1:0] s2_h1;
    logic [CH_W-1:0] s2_h2;
    logic [CH_W-1:0] r_h1;
    logic [CH_W-1:0] r_h2;
    logic [CH_W-1:0] r_o1;
    logic [CH_W-1:0] r_o2;

    // Vertical tap; the bottom row repeats its center
    assign s1_below = i_s1_flush ? i_center : i_px;
    assign s1_v     = blur3(i_above, i_center, s1_below);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_v     <= s1_v;
            r_pix_c <= i_center;
        end
    end

    // Horizontal taps: regular window and the replicated right edge
    assign s2_new_left = i_s2.col_zero ? r_v : r_center;
    assign s2_h1       = blur3(r_left, r_center, r_v);
    assign s2_h2       = blur3(s2_new_left, r_v, r_v);

    // Slide the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_center <= '0;
            r_orig   <= '0;
        end else if (i_adv && i_s2.valid) begin
            r_left   <= s2_new_left;
            r_center <= r_v;
            r_orig   <= r_pix_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_h1 <= s2_h1;
            r_h2 <= s2_h2;
            r_o1 <= r_orig;
            r_o2 <= r_pix_c;
        end
    end

    // Blend with the original pixel
    assign o_res1 = blend(r_o1, r_h1);
    assign o_res2 = blend(r_o2, r_h2);

endmodule

/* design/sbb_out_merge.sv */
// ----------------------------------------------------------------------------
// sbb_out_merge: combine the lanes into result beats and buffer them
// A beat may give two results; a two-entry buffer holds them and drives the
// output channel from its head register.
// ----------------------------------------------------------------------------
module sbb_out_merge
    import sbb_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  t_ctl                           i_s3,
    input  logic [NUM_LANES-1:0][CH_W-1:0] i_res1,
    input  logic [NUM_LANES-1:0][CH_W-1:0] i_res2,
    input  logic                           i_out_ready,
    output logic                           o_can_load,
    output logic                           o_out_valid,
    output t_result                        o_result
);

    logic [1:0] r_count;
    logic [1:0] n_count;
    t_result    r_slot0;
    t_result    n_slot0;
    t_result    r_slot1;
    t_result    n_slot1;
    t_result    res1;
    t_result    res2;
    logic       emit1;
    logic       emit2;
    logic       pop;

    // Merge lane outputs
    assign emit1 = i_s3.valid && !i_s3.col_zero;
    assign emit2 = i_s3.valid && i_s3.last_col;

    always_comb begin
        res1.pix           = i_res1;
        res1.last_of_run   = !i_s3.last_col;
        res1.last_of_frame = 1'b0;
        res2.pix           = i_res2;
        res2.last_of_run   = 1'b1;
        res2.last_of_frame = i_s3.flush;
    end

    assign pop        = (r_count != 2'd0) && i_out_ready;
    assign o_can_load = (r_count == 2'd0) || ((r_count == 2'd1) && i_out_ready);

    // Drop the head on a taken beat, then append new results
    always_comb begin
        n_count = r_count;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (pop) begin
            n_count = r_count - 2'd1;
            n_slot0 = r_slot1;
        end
        if (i_load) begin
            unique case ({emit1, emit2})
                2'b11: begin
                    n_slot0 = res1;
                    n_slot1 = res2;
                    n_count = 2'd2;
                end
                2'b10: begin
                    n_slot0 = res1;
                    n_count = 2'd1;
                end
                2'b01: begin
                    n_slot0 = res2;
                    n_count = 2'd1;
                end
                2'b00: begin
                    // left-edge beat: nothing to append
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_out_valid = (r_count != 2'd0);
    assign o_result    = r_slot0;

endmodule

/* design/separable_blur_blend_pixels.sv */
// ----------------------------------------------------------------------------
// separable_blur_blend_pixels: 3x3 separable blur blended with the original
// A result passes through stages s1, s2, s3 and the output buffer's head register.
// Throughput: one input beat per cycle while the output is ready; the second
// result of a row end leaves in the slot of the next row's first beat, which
// gives none.
// Reset (synchronous, active low) clears pipeline and counters, presets registers;
// line memories are not cleared and hold no data until the first row is written.
// ----------------------------------------------------------------------------
module separable_blur_blend_pixels
    import sbb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // Pixel input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_cmd,
    input  logic [CH_W-1:0]   i_chan0_in,
    input  logic [CH_W-1:0]   i_chan1_in,
    input  logic [CH_W-1:0]   i_chan2_in,
    // Result output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CH_W-1:0]   o_chan0_out,
    output logic [CH_W-1:0]   o_chan1_out,
    output logic [CH_W-1:0]   o_chan2_out,
    output logic              o_last_of_run,
    output logic              o_last_of_frame
);

    logic [CFG_WID_W-1:0]           r_frame_width;
    logic [CFG_HGT_W-1:0]           r_frame_height;
    t_reg_idx                       reg_idx;
    logic                           cfg_wr;

    logic [CNT_W-1:0]               eff_w;
    logic [CFG_HGT_W-1:0]           eff_h;
    logic [COL_W-1:0]               r_col_count;
    logic [CFG_HGT_W-1:0]           r_row_count;
    logic [CNT_W-1:0]               col_ext;
    logic [COL_W-1:0]               col;
    logic                           last_col;
    logic                           flush;
    logic                           kind_ok;
    logic                           in_fire;
    logic                           acc;
    logic                           adv;
    logic                           can_load;

    t_ctl                           r_s1;
    t_ctl                           r_s2;
    t_ctl                           r_s3;
    logic [COL_W-1:0]               r_s1_col;
    logic [PIX_W-1:0]               r_s1_px;

    logic                           wr_en;
    logic [PIX_W-1:0]               wr_above;
    logic [PIX_W-1:0]               ls_above;
    logic [PIX_W-1:0]               ls_middle;

    logic [NUM_LANES-1:0][CH_W-1:0] lane_res1;
    logic [NUM_LANES-1:0][CH_W-1:0] lane_res2;
    t_result                        out_res;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RESET_WIDTH;
            r_frame_height <= RESET_HEIGHT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_WID_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_HGT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = DATA_W'(r_frame_height);
        endcase
    end

    // Effective frame size
    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = CNT_W'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            eff_w = CNT_W'(MAX_WIDTH);
        end else begin
            eff_w = CNT_W'(r_frame_width);
        end
    end

    assign eff_h = (r_frame_height == '0) ? CFG_HGT_W'(1) : r_frame_height;

    // Position of this beat and its kind
    assign col_ext  = ({1'b0, r_col_count} >= eff_w) ? (eff_w - CNT_W'(1))
                                                     : {1'b0, r_col_count};
    assign col      = col_ext[COL_W-1:0];
    assign last_col = (col_ext + CNT_W'(1)) >= eff_w;
    assign flush    = r_row_count >= eff_h;
    assign kind_ok  = (i_cmd == flush);

    assign o_in_ready = adv;
    assign in_fire    = i_in_valid && adv;
    assign acc        = in_fire && kind_ok;

    // Advance column and row counters on a beat of the expected kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
        end else if (acc) begin
            if (last_col) begin
                r_col_count <= '0;
                r_row_count <= flush ? '0 : (r_row_count + CFG_HGT_W'(1));
            end else begin
                r_col_count <= col + COL_W'(1);
            end
        end
    end

    // Pipeline control; stalls only while the buffer cannot take stage 3 results
    assign adv = !(r_s3.valid && (!r_s3.col_zero || r_s3.last_col)) || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (adv) begin
            r_s1.valid     <= acc;
            r_s1.first_row <= !flush && (r_row_count == '0);
            r_s1.flush     <= flush;
            r_s1.col_zero  <= (col == '0);
            r_s1.last_col  <= last_col;
            r_s2.valid     <= r_s1.valid && !r_s1.first_row;
            r_s2.first_row <= r_s1.first_row;
            r_s2.flush     <= r_s1.flush;
            r_s2.col_zero  <= r_s1.col_zero;
            r_s2.last_col  <= r_s1.last_col;
            r_s3           <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_col <= col;
            r_s1_px  <= {i_chan2_in, i_chan1_in, i_chan0_in};
        end
    end

    // Line stores: shift the column down one row
    assign wr_en    = adv && r_s1.valid && !r_s1.flush;
    assign wr_above = r_s1.first_row ? r_s1_px : ls_middle;

    sbb_line_store u_line_store (
        .i_clk       (i_clk),
        .i_rd_en     (acc),
        .i_rd_addr   (col),
        .i_wr_en     (wr_en),
        .i_wr_addr   (r_s1_col),
        .i_wr_above  (wr_above),
        .i_wr_middle (r_s1_px),
        .o_above     (ls_above),
        .o_middle    (ls_middle)
    );

    // One lane per channel
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        sbb_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (adv),
            .i_s1_flush (r_s1.flush),
            .i_s2       (r_s2),
            .i_above    (ls_above[l*CH_W +: CH_W]),
            .i_center   (ls_middle[l*CH_W +: CH_W]),
            .i_px       (r_s1_px[l*CH_W +: CH_W]),
            .o_res1     (lane_res1[l]),
            .o_res2     (lane_res2[l])
        );
    end

    sbb_out_merge u_out_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (adv && r_s3.valid),
        .i_s3        (r_s3),
        .i_res1      (lane_res1),
        .i_res2      (lane_res2),
        .i_out_ready (i_out_ready),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_result    (out_res)
    );

    assign o_chan0_out     = out_res.pix[0*CH_W +: CH_W];
    assign o_chan1_out     = out_res.pix[1*CH_W +: CH_W];
    assign o_chan2_out     = out_res.pix[2*CH_W +: CH_W];
    assign o_last_of_run   = out_res.last_of_run;
    assign o_last_of_frame = out_res.last_of_frame;

endmodule

/* design/sbb_checker.sv */
// ----------------------------------------------------------------------------
// sbb_checker: port-level checks for the blur and blend block
// Watches the output channel, input back-pressure and the result flags.
// ----------------------------------------------------------------------------
module sbb_checker
    import sbb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [CH_W-1:0]   o_chan0_out,
    input logic [CH_W-1:0]   o_chan1_out,
    input logic [CH_W-1:0]   o_chan2_out,
    input logic              o_last_of_run,
    input logic              o_last_of_frame
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_chan0_out) && $stable(o_chan1_out) && $stable(o_chan2_out)
            && $stable(o_last_of_run) && $stable(o_last_of_frame))
        else $error("result beat changed while stalled");

    // Back-pressure on the input only while a result waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    // Frame end is always marked as the last of its run
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_frame |-> o_last_of_run)
        else $error("frame end not marked as last of run");

    // Output empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind separable_blur_blend_pixels sbb_checker u_sbb_checker (.*);

/* tb/separable_blur_blend_pixels_test.sv */
// ----------------------------------------------------------------------------
// separable_blur_blend_pixels_test: self-checking bench for the blur and blend
// Drives pixel and flush beats into the block, predicts every blended result
// with an independent model of the line stores and the 3-tap blur, and checks
// each output beat in order. Covers directed edge frames, register limits,
// mid-frame geometry changes, back-pressure and random frames with stray beats.
// ----------------------------------------------------------------------------
module separable_blur_blend_pixels_test;
    import sbb_pkg::*;

    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_BEATS    = 1000;
    localparam int NORMAL_IDLE_PCT = 32;

    // Block ports
    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid   = 1'b0;
    logic              o_in_ready;
    logic              i_cmd        = 1'b0;
    logic [CH_W-1:0]   i_chan0_in   = '0;
    logic [CH_W-1:0]   i_chan1_in   = '0;
    logic [CH_W-1:0]   i_chan2_in   = '0;
    logic              o_out_valid;
    logic              i_out_ready  = 1'b0;
    logic [CH_W-1:0]   o_chan0_out;
    logic [CH_W-1:0]   o_chan1_out;
    logic [CH_W-1:0]   o_chan2_out;
    logic              o_last_of_run;
    logic              o_last_of_frame;

    // Bench control
    int send_idle_pct     = NORMAL_IDLE_PCT;
    int recv_idle_pct     = NORMAL_IDLE_PCT;
    int recv_hold_cycles  = 0;
    int mismatches        = 0;
    int beats_taken       = 0;

    // Predicted block state
    logic [CFG_WID_W-1:0] cfg_width  = RESET_WIDTH;
    logic [CFG_HGT_W-1:0] cfg_height = RESET_HEIGHT;
    logic [PIX_W-1:0]     line_above  [MAX_WIDTH];
    logic [PIX_W-1:0]     line_middle [MAX_WIDTH];
    logic [PIX_W-1:0]     vert_left   = '0;
    logic [PIX_W-1:0]     vert_center = '0;
    logic [PIX_W-1:0]     orig_center = '0;
    int unsigned          col_pos     = 0;
    logic [15:0]          row_pos     = '0;
    t_result              expected_pixels [$];

    separable_blur_blend_pixels DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_chan0_in      (i_chan0_in),
        .i_chan1_in      (i_chan1_in),
        .i_chan2_in      (i_chan2_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_chan0_out     (o_chan0_out),
        .o_chan1_out     (o_chan1_out),
        .o_chan2_out     (o_chan2_out),
        .o_last_of_run   (o_last_of_run),
        .o_last_of_frame (o_last_of_frame)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Effective geometry: zero counts as one, width saturates at the store depth
    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    // Vertical or horizontal 3-tap blur on all three lanes
    function automatic logic [PIX_W-1:0] blur_pixel(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] c,
                                                    input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] r;
        int unsigned      t;
        for (int k = 0; k < NUM_LANES; k++) begin
            t = (129 + 255 * int'(c[CH_W*k +: CH_W])
                 + 2 * (int'(a[CH_W*k +: CH_W]) + int'(b[CH_W*k +: CH_W]))) / 259;
            r[CH_W*k +: CH_W] = t[CH_W-1:0];
        end
        return r;
    endfunction

    // Mix a small share of the blur back into the original
    function automatic logic [PIX_W-1:0] blend_pixel(input logic [PIX_W-1:0] orig,
                                                     input logic [PIX_W-1:0] bl);
        logic [PIX_W-1:0] r;
        int unsigned      t;
        for (int k = 0; k < NUM_LANES; k++) begin
            t = (2 * int'(bl[CH_W*k +: CH_W]) + 253 * int'(orig[CH_W*k +: CH_W])) / 255;
            r[CH_W*k +: CH_W] = t[CH_W-1:0];
        end
        return r;
    endfunction

    // Advance the predicted state by one beat; queue the results it yields.
    // Returns 0 for a beat of the wrong kind, which the block drops.
    function automatic bit predict_blur_blend(input logic cmd, input logic [PIX_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      col;
        bit               flush;
        bit               last_col;
        logic [PIX_W-1:0] center;
        logic [PIX_W-1:0] below;
        logic [PIX_W-1:0] vcol;
        w     = eff_width();
        h     = eff_height();
        flush = (row_pos >= h);
        if (cmd != flush) return 1'b0;
        col      = (col_pos >= w) ? w - 1 : col_pos;
        last_col = (col + 1 >= w);
        if (!flush && row_pos == 0) begin
            // first row only fills both line stores
            line_above[col]  = px;
            line_middle[col] = px;
        end else begin
            center = line_middle[col];
            below  = flush ? center : px;
            vcol   = blur_pixel(line_above[col], center, below);
            if (!flush) begin
                line_above[col]  = center;
                line_middle[col] = px;
            end
            if (col == 0) begin
                // replicate the left edge
                vert_left   = vcol;
                vert_center = vcol;
            end else begin
                expected_pixels.push_back(t_result'{
                    blend_pixel(orig_center, blur_pixel(vert_left, vert_center, vcol)),
                    !last_col, 1'b0});
                vert_left   = vert_center;
                vert_center = vcol;
            end
            orig_center = center;
            if (last_col) begin
                // replicate the right edge for the row's last pixel
                expected_pixels.push_back(t_result'{
                    blend_pixel(orig_center, blur_pixel(vert_left, vert_center, vert_center)),
                    1'b1, flush});
            end
        end
        if (last_col) begin
            col_pos = 0;
            row_pos = flush ? 16'd0 : 16'(row_pos + 1);
        end else begin
            col_pos = col + 1;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            i_out_ready      <= 1'b0;
            recv_hold_cycles <= recv_hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every output beat against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result beat: chan0_out %0d chan1_out %0d chan2_out %0d",
                       o_chan0_out, o_chan1_out, o_chan2_out);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("chan0_out", want.pix[0 +: CH_W], o_chan0_out);
                check_field("chan1_out", want.pix[CH_W +: CH_W], o_chan1_out);
                check_field("chan2_out", want.pix[2*CH_W +: CH_W], o_chan2_out);
                check_field("last_of_run", want.last_of_run, o_last_of_run);
                check_field("last_of_frame", want.last_of_frame, o_last_of_frame);
            end
        end
    end

    // Send one beat with a random lead-in gap; predict once it is accepted
    task automatic send_beat(input logic cmd, input logic [PIX_W-1:0] px, output bit taken);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_chan0_in <= px[0 +: CH_W];
        i_chan1_in <= px[CH_W +: CH_W];
        i_chan2_in <= px[2*CH_W +: CH_W];
        do @(posedge i_clk); while (!o_in_ready);
        taken = predict_blur_blend(cmd, px);
        if (taken) beats_taken++;
    endtask

    // Stop sending, wait out every expected result, then let the pipeline settle
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic read_reg(input t_reg_idx idx, input logic [DATA_W-1:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(int'(idx) * 4);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $error("register %s: expected %0d, got %0d", idx.name(), want, prdata);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a register while the block is idle, mirror it, then read it back
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FRAME_WIDTH) cfg_width = value[CFG_WID_W-1:0];
        else cfg_height = value[CFG_HGT_W-1:0];
        read_reg(idx, (idx == REG_FRAME_WIDTH) ? DATA_W'(cfg_width) : DATA_W'(cfg_height));
    endtask

    // Run one frame to the end of its flush row, with optional stray beats
    // and at most one mid-frame shrink of the width or the height
    task automatic send_frame(input int noise_pct, input bit allow_shrink);
        bit in_flush;
        bit taken;
        bit shrunk;
        bit frame_done;
        shrunk     = 1'b0;
        frame_done = 1'b0;
        while (!frame_done) begin
            if (allow_shrink && !shrunk && $urandom_range(99) == 0) begin
                drain_results();
                if ($urandom_range(1)) write_reg(REG_FRAME_WIDTH, $urandom_range(eff_width(), 1));
                else write_reg(REG_FRAME_HEIGHT, $urandom_range(eff_height(), 1));
                shrunk = 1'b1;
            end
            in_flush = (row_pos >= eff_height());
            if ($urandom_range(99) < noise_pct) begin
                send_beat(!in_flush, PIX_W'($urandom), taken);
            end else begin
                send_beat(in_flush, PIX_W'($urandom), taken);
                frame_done = in_flush && col_pos == 0;
            end
        end
    endtask

    task automatic test_register_reset();
        read_reg(REG_FRAME_WIDTH, DATA_W'(RESET_WIDTH));
        read_reg(REG_FRAME_HEIGHT, DATA_W'(RESET_HEIGHT));
    endtask

    // 3x3 frame with extreme channel values and stray beats of the wrong kind
    task automatic test_small_frame();
        logic [PIX_W-1:0] pixels [9] = '{24'h000000, 24'hFFFFFF, 24'h000000,
                                         24'hFF00FF, 24'h00FF00, 24'hFFFFFF,
                                         24'h0000FF, 24'h123456, 24'hFF0000};
        bit taken;
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        for (int i = 0; i < 9; i++) begin
            send_beat(1'b0, pixels[i], taken);
            // flush beat while rows are still due: dropped
            if (i == 4) send_beat(1'b1, 24'hFFFFFF, taken);
        end
        // pixel while flush beats are due: dropped
        send_beat(1'b0, 24'hABCDEF, taken);
        repeat (3) send_beat(1'b1, 24'h000000, taken);
        drain_results();
    endtask

    // One-column frames, including zero width and height
    task automatic test_narrow_frames();
        bit taken;
        write_reg(REG_FRAME_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, 2);
        send_beat(1'b0, 24'h000000, taken);
        send_beat(1'b0, 24'hFFFFFF, taken);
        send_beat(1'b1, 24'h5A5A5A, taken);
        drain_results();
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 0);
        send_beat(1'b0, 24'hFFFFFF, taken);
        send_beat(1'b1, 24'hFFFFFF, taken);
        drain_results();
    endtask

    // Register limits and geometry shrunk in the middle of a frame
    task automatic test_register_limits();
        bit taken;
        write_reg(REG_FRAME_WIDTH, 4095);
        write_reg(REG_FRAME_HEIGHT, 65535);
        repeat (3) send_beat(1'b0, PIX_W'($urandom), taken);
        drain_results();
        // column already past the new width: the row ends here
        write_reg(REG_FRAME_WIDTH, 2);
        repeat (5) send_beat(1'b0, PIX_W'($urandom), taken);
        drain_results();
        // rows already past the new height: go straight to flush
        write_reg(REG_FRAME_HEIGHT, 2);
        repeat (2) send_beat(1'b1, PIX_W'($urandom), taken);
        drain_results();
    endtask

    // Hold the output off long enough to fill the block, then pause the
    // input until everything has drained
    task automatic test_backpressure();
        write_reg(REG_FRAME_WIDTH, 24);
        write_reg(REG_FRAME_HEIGHT, 3);
        recv_hold_cycles = 400;
        send_frame(0, 1'b0);
        drain_results();
        send_frame(0, 1'b0);
        drain_results();
    endtask

    task automatic test_random_frames();
        int start_count;
        int pick;
        start_count = beats_taken;
        while (beats_taken - start_count < RANDOM_BEATS) begin
            // stretch with no idling on either side
            if (beats_taken - start_count inside {[400:700]}) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = NORMAL_IDLE_PCT;
                recv_idle_pct = NORMAL_IDLE_PCT;
            end
            if ($urandom_range(99) < 60) begin
                drain_results();
                pick = $urandom_range(99);
                if (pick < 5) write_reg(REG_FRAME_WIDTH, 0);
                else if (pick < 70) write_reg(REG_FRAME_WIDTH, $urandom_range(8, 1));
                else if (pick < 95) write_reg(REG_FRAME_WIDTH, $urandom_range(40, 9));
                else write_reg(REG_FRAME_WIDTH, $urandom_range(160, 41));
                pick = $urandom_range(99);
                if (pick < 5) write_reg(REG_FRAME_HEIGHT, 0);
                else if (pick < 85) write_reg(REG_FRAME_HEIGHT, $urandom_range(5, 1));
                else write_reg(REG_FRAME_HEIGHT, $urandom_range(14, 6));
            end
            send_frame(5, 1'b1);
        end
        send_idle_pct = NORMAL_IDLE_PCT;
        recv_idle_pct = NORMAL_IDLE_PCT;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_register_reset();
        test_small_frame();
        test_narrow_frames();
        test_register_limits();
        test_backpressure();
        test_random_frames();
        drain_results();
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("separable_blur_blend_pixels test passed");
        end else begin
            $display("separable_blur_blend_pixels test failed");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #5000000;
        $display("separable_blur_blend_pixels test failed");
        $finish;
    end

endmodule
